### design/gratu_pkg.sv
// Shared types and constants of the growth rate adaptive threshold unit.
`default_nettype none
package gratu_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] REG_WINDOW_SIZE     = 8'd0;
    localparam logic [7:0] REG_MIN_GROWTH_RATE = 8'd1;
    localparam logic [7:0] REG_ADJUST_GAIN     = 8'd2;
    localparam logic [7:0] REG_MIN_THRESHOLD   = 8'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_WINDOW_SIZE     = 16'd10;
    localparam logic [31:0] RST_MIN_GROWTH_RATE = 32'd655;
    localparam logic [15:0] RST_ADJUST_GAIN     = 16'd4096;
    localparam logic [31:0] RST_MIN_THRESHOLD   = 32'd66;

    // log2(e) and ln(2) in Q30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // Number of terms of the exponential series
    localparam logic [3:0] SER_TERMS = 4'd13;

    // Widths of the shared units
    localparam int DIV_W  = 64;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = 7;
    localparam int MOP_W  = 33;

    // Request to the shared divider
    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
        logic [CNT_W-1:0]   nbits;
    } div_req_t;

endpackage
`default_nettype wire

### design/gratu_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module gratu_div
    import gratu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    // Sequence the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dq_next   = dq_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            rem_next  = '0;
            den_next  = req.divisor;
            dq_next   = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dq_next  = {dq_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

### design/gratu_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module gratu_mul
    import gratu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [MOP_W-1:0]  op_a,
    input  wire logic signed [MOP_W-1:0]  op_b,
    output logic signed [2*MOP_W-1:0]     prod
);

    logic signed [2*MOP_W-1:0] prod_reg;

    // Register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### design/growth_rate_adaptive_threshold_unit.sv
// Top level of the growth rate adaptive threshold unit: sequencer and state.
//
// Each input word carries one coverage sample; each output word carries the
// growth rate against the previous sample, the threshold, a warmed-up flag
// and a saturation flag. Both channels use valid/stall; a word moves on a
// rising edge with valid high and stall low. Configuration registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high and writes to indexes above three are dropped.
// One sample is worked at a time; in_stall stays high until its result is
// loaded into the output register. The growth division runs on the shared
// one-bit-per-cycle divider for 64 quotient bits, the baseline division for
// 48 quotient bits, and the 13-term exponential series makes 13 passes, each
// of one multiply and one 31-bit division. A first sample in warm-up skips
// the divider, a later sample in warm-up uses only the growth division, and
// a later warmed-up sample uses all three; a stalling receiver delays the
// next sample further.
// While the receiver stalls a finished word stays in the output register and
// the next result waits in the final state. Reset clears the sample history,
// the count and the sum, loads the default registers and sets the stored
// threshold to the default minimum growth rate.
`default_nettype none
module growth_rate_adaptive_threshold_unit
    import gratu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] coverage,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      growth_rate,
    output logic [31:0]      threshold,
    output logic             warmed_up,
    output logic             saturated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GDIV = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_BDIV = 4'd3;
    localparam logic [3:0] S_DIFF = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_MX   = 4'd6;
    localparam logic [3:0] S_MY   = 4'd7;
    localparam logic [3:0] S_MZ   = 4'd8;
    localparam logic [3:0] S_SM   = 4'd9;
    localparam logic [3:0] S_SD   = 4'd10;
    localparam logic [3:0] S_SW   = 4'd11;
    localparam logic [3:0] S_FM   = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;
    localparam logic [3:0] S_M2   = 4'd15;

    localparam logic signed [35:0] X_LIM  = 36'sd64 <<< FRAC_BITS;
    localparam int                 T_SH   = 24 - FRAC_BITS;
    localparam logic [63:0]        TOP_P  = 64'h7FFF_FFFF;
    localparam logic [63:0]        TOP_N  = 64'h8000_0000;
    localparam logic [30:0]        ONE_Q30 = 31'h4000_0000;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    // Configuration registers
    logic [15:0]        win_reg;
    logic signed [31:0] mgr_reg;
    logic signed [15:0] gain_reg;
    logic signed [31:0] mthr_reg;

    // Block state
    logic [31:0]        prev_reg;
    logic [31:0]        count_reg, count_next;
    logic signed [47:0] sum_reg, sum_next;
    logic signed [31:0] cthr_reg, cthr_next;

    // Working registers
    logic [3:0]         state_reg, state_next;
    logic               gneg_reg, gneg_next;
    logic signed [31:0] growth_reg, growth_next;
    logic signed [31:0] base_reg, base_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [7:0]  k_reg, k_next;
    logic [29:0]        z_reg, z_next;
    logic [30:0]        term_reg, term_next;
    logic [31:0]        esum_reg, esum_next;
    logic [3:0]         n_reg, n_next;
    logic               sat_reg, sat_next;
    logic               warm_reg, warm_next;
    logic signed [31:0] thro_reg, thro_next;

    // Output register
    logic               ov_reg, ov_next;
    logic [31:0]        og_reg, og_next;
    logic [31:0]        ot_reg, ot_next;
    logic               ow_reg, ow_next;
    logic               os_reg, os_next;

    // Shared units
    div_req_t                   dreq;
    logic                       ddone;
    logic [DIV_W-1:0]           dquo;
    logic signed [MOP_W-1:0]    ma, mb;
    logic signed [2*MOP_W-1:0]  mp;

    // Combinational helpers
    logic               accept;
    logic [32:0]        cdiff;
    logic [31:0]        gmag;
    logic [32:0]        gres;
    logic signed [48:0] s49;
    logic [47:0]        smag;
    logic [32:0]        bres;
    logic signed [32:0] d33;
    logic signed [35:0] xv;
    logic signed [31:0] xc;
    logic [31:0]        tmag;
    logic               tneg;
    logic signed [8:0]  s9;
    logic [8:0]         sh9;
    logic [63:0]        mval;
    logic [63:0]        top;
    logic [63:0]        res;
    logic               fsat;
    logic signed [31:0] nt;

    // Saturate a sign and magnitude quotient to 32 bits signed: {flag, value}
    function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] q);
        logic [32:0] r;
        if (neg)
        begin
            if (q > TOP_N)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, 32'(-q)};
        end
        else
        begin
            if (q > TOP_P)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, q[31:0]};
        end
        return r;
    endfunction

    gratu_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (dquo)
    );

    gratu_mul u_mul
    (
        .clk  (clk),
        .op_a (ma),
        .op_b (mb),
        .prod (mp)
    );

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Form the sample difference and the growth magnitude
    always_comb
    begin
        cdiff = {1'b0, coverage} - {1'b0, prev_reg};
        gmag  = cdiff[32] ? 32'(-cdiff) : cdiff[31:0];
    end

    // Pick multiplier operands for the current step
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_M1:
            begin
                ma = MOP_W'(gain_reg);
                mb = MOP_W'(diff_reg);
            end
            S_M2:
            begin
                ma = MOP_W'(t_reg);
                mb = {2'b00, LOG2E_Q30};
            end
            S_MY:
            begin
                ma = {3'b000, mp[53:30], 6'b0};
                mb = {3'b000, LN2_Q30};
            end
            S_SM:
            begin
                ma = {2'b00, term_reg};
                mb = {3'b000, z_reg};
            end
            S_FM:
            begin
                ma = {1'b0, tmag};
                mb = {1'b0, esum_reg};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Threshold magnitude and sign
    always_comb
    begin
        tneg = cthr_reg[31];
        tmag = tneg ? 32'(-cthr_reg) : cthr_reg;
    end

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        cthr_next   = cthr_reg;
        gneg_next   = gneg_reg;
        growth_next = growth_reg;
        base_next   = base_reg;
        diff_next   = diff_reg;
        t_next      = t_reg;
        k_next      = k_reg;
        z_next      = z_reg;
        term_next   = term_reg;
        esum_next   = esum_reg;
        n_next      = n_reg;
        sat_next    = sat_reg;
        warm_next   = warm_reg;
        thro_next   = thro_reg;
        dreq        = '0;
        gres        = '0;
        s49         = '0;
        smag        = '0;
        bres        = '0;
        d33         = '0;
        xv          = '0;
        xc          = '0;
        s9          = '0;
        sh9         = '0;
        mval        = '0;
        top         = '0;
        res         = '0;
        fsat        = 1'b0;
        nt          = '0;
        ov_next     = ov_reg;
        og_next     = og_reg;
        ot_next     = ot_reg;
        ow_next     = ow_reg;
        os_next     = os_reg;

        // Drop the output word once taken
        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        // Load the stored threshold with a new minimum rate before the first sample
        if (cfg_valid && cfg_ready && (cfg_index == REG_MIN_GROWTH_RATE)
            && (count_reg == '0))
            cthr_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sat_next    = 1'b0;
                    growth_next = '0;
                    if (count_reg != 32'hFFFF_FFFF)
                        count_next = count_reg + 1'b1;
                    if (count_next >= 32'd2)
                    begin
                        gneg_next     = cdiff[32];
                        dreq.start    = 1'b1;
                        dreq.dividend = 64'(gmag) << FRAC_BITS;
                        dreq.divisor  = (prev_reg == '0) ? 32'd1 : prev_reg;
                        dreq.nbits    = CNT_W'(64);
                        state_next    = S_GDIV;
                    end
                    else
                        state_next = S_CHK;
                end
            end
            S_GDIV:
            begin
                if (ddone)
                begin
                    gres        = sat_mag(gneg_reg, dquo);
                    growth_next = gres[31:0];
                    s49 = {sum_reg[47], sum_reg} + 49'(signed'(gres[31:0]));
                    if (s49[48] != s49[47])
                    begin
                        sum_next = s49[48] ? SUM_MIN : SUM_MAX;
                        sat_next = 1'b1;
                    end
                    else
                        sum_next = s49[47:0];
                    if (gres[32])
                        sat_next = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                warm_next = (count_reg >= {16'b0, win_reg});
                base_next = '0;
                if (count_reg < {16'b0, win_reg})
                begin
                    thro_next  = mgr_reg;
                    state_next = S_DONE;
                end
                else if (count_reg > 32'd1)
                begin
                    smag          = sum_reg[47] ? 48'(-sum_reg) : sum_reg;
                    dreq.start    = 1'b1;
                    dreq.dividend = {smag, 16'b0};
                    dreq.divisor  = count_reg - 1'b1;
                    dreq.nbits    = CNT_W'(48);
                    state_next    = S_BDIV;
                end
                else
                    state_next = S_DIFF;
            end
            S_BDIV:
            begin
                if (ddone)
                begin
                    bres      = sat_mag(sum_reg[47], dquo);
                    base_next = bres[31:0];
                    if (bres[32])
                        sat_next = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                d33 = 33'(growth_reg) - 33'(base_reg);
                if (d33[32] != d33[31])
                begin
                    diff_next = d33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    sat_next  = 1'b1;
                end
                else
                    diff_next = d33[31:0];
                state_next = S_M1;
            end
            S_M1:
            begin
                state_next = S_MX;
            end
            S_MX:
            begin
                // Floor of gain * diff / 2^12, clamped to +-64.0
                xv = mp[47:12];
                if (xv > X_LIM)
                begin
                    xc       = 32'(X_LIM);
                    sat_next = 1'b1;
                end
                else if (xv < -X_LIM)
                begin
                    xc       = 32'(-X_LIM);
                    sat_next = 1'b1;
                end
                else
                    xc = xv[31:0];
                t_next     = xc <<< T_SH;
                state_next = S_M2;
            end
            S_M2:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                // Split the base-2 exponent into integer and fraction
                k_next     = mp[61:54];
                state_next = S_MZ;
            end
            S_MZ:
            begin
                z_next     = mp[59:30];
                term_next  = ONE_Q30;
                esum_next  = {1'b0, ONE_Q30};
                n_next     = 4'd1;
                state_next = S_SM;
            end
            S_SM:
            begin
                state_next = S_SD;
            end
            S_SD:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {mp[60:30], 33'b0};
                dreq.divisor  = {28'b0, n_reg};
                dreq.nbits    = CNT_W'(31);
                state_next    = S_SW;
            end
            S_SW:
            begin
                if (ddone)
                begin
                    term_next = dquo[30:0];
                    esum_next = esum_reg + {1'b0, dquo[30:0]};
                    if (n_reg == SER_TERMS)
                        state_next = S_FM;
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = S_SM;
                    end
                end
            end
            S_FM:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Scale by 2^k, saturate, restore the sign, clamp below
                mval = mp[63:0];
                top  = tneg ? TOP_N : TOP_P;
                s9   = 9'sd30 - 9'(k_reg);
                if (!s9[8] && (s9 != 9'sd0))
                begin
                    if (s9 >= 9'sd64)
                        res = '0;
                    else
                        res = mval >> s9[5:0];
                end
                else
                begin
                    sh9 = 9'(-s9);
                    if (sh9 >= 9'd32)
                        res = top + 1'b1;
                    else if (mval > (top >> sh9[4:0]))
                        res = top + 1'b1;
                    else
                        res = mval << sh9[4:0];
                end
                if (res > top)
                begin
                    fsat = 1'b1;
                    res  = top;
                end
                if (cthr_reg == '0)
                    nt = '0;
                else
                begin
                    nt = tneg ? 32'(-res) : res[31:0];
                    if (fsat)
                        sat_next = 1'b1;
                end
                cthr_next  = (nt > mthr_reg) ? nt : mthr_reg;
                thro_next  = cthr_next;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    og_next    = growth_reg;
                    ot_next    = thro_reg;
                    ow_next    = warm_reg;
                    os_next    = sat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            win_reg   <= RST_WINDOW_SIZE;
            mgr_reg   <= RST_MIN_GROWTH_RATE;
            gain_reg  <= RST_ADJUST_GAIN;
            mthr_reg  <= RST_MIN_THRESHOLD;
            prev_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            cthr_reg  <= RST_MIN_GROWTH_RATE;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            cthr_reg  <= cthr_next;
            if (accept)
                prev_reg <= coverage;
            // Hold configuration writes; user must write when idle, unchecked
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:     win_reg  <= cfg_data[15:0];
                    REG_MIN_GROWTH_RATE: mgr_reg  <= cfg_data;
                    REG_ADJUST_GAIN:     gain_reg <= cfg_data[15:0];
                    REG_MIN_THRESHOLD:   mthr_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        gneg_reg   <= gneg_next;
        growth_reg <= growth_next;
        base_reg   <= base_next;
        diff_reg   <= diff_next;
        t_reg      <= t_next;
        k_reg      <= k_next;
        z_reg      <= z_next;
        term_reg   <= term_next;
        esum_reg   <= esum_next;
        n_reg      <= n_next;
        sat_reg    <= sat_next;
        warm_reg   <= warm_next;
        thro_reg   <= thro_next;
        og_reg     <= og_next;
        ot_reg     <= ot_next;
        ow_reg     <= ow_next;
        os_reg     <= os_next;
    end

    assign out_valid   = ov_reg;
    assign growth_rate = og_reg;
    assign threshold   = ot_reg;
    assign warmed_up   = ow_reg;
    assign saturated   = os_reg;

endmodule
`default_nettype wire

### tb/growth_rate_adaptive_threshold_checker.sv
// Checker of the growth rate adaptive threshold unit: predicts and compares output words.
module growth_rate_adaptive_threshold_checker
    import gratu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] coverage,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] growth_rate,
    input  wire logic [31:0] threshold,
    input  wire logic        warmed_up,
    input  wire logic        saturated,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint I32_MAX = 64'sh7FFF_FFFF;
    localparam longint I32_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic [31:0] growth;
        logic [31:0] thr;
        logic        warm;
        logic        sat;
    } rate_word_t;

    // Shadow of the configuration registers
    logic [15:0] win_size;
    int          min_rate;
    int          gain;
    int          min_thr;

    // Shadow of the block state
    logic [31:0] prev_cov;
    logic [31:0] n_samples;
    longint      rate_sum;
    int          cur_thr;

    rate_word_t  expected_words[$];

    function automatic longint sat_clip(longint v, longint lo, longint hi, ref logic flag);
        if (v > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Scale a threshold by exp(x), x in FRAC 16 fixed point
    function automatic int exp_scale(int thr_in, longint x_in, ref logic flag);
        longint lim, x, t, y, k, s;
        longint unsigned fr, z, term, acc, mag, m, top;
        int sh;
        lim = 64'sd64 <<< 16;
        x = sat_clip(x_in, -lim, lim, flag);
        t = x * 256;
        y = (t * longint'(LOG2E_Q30)) >>> 30;
        k = y >>> 24;
        fr = longint'(y - (k <<< 24));
        z = ((fr << 6) * longint'(LN2_Q30)) >> 30;
        term = 64'd1 << 30;
        acc = term;
        for (int n = 1; n <= 13; n++)
        begin
            term = ((term * z) >> 30) / longint'(n);
            acc += term;
        end
        if (thr_in == 0)
            return 0;
        mag = (thr_in < 0) ? longint'(-longint'(thr_in)) : longint'(thr_in);
        top = (thr_in < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        m = mag * acc;
        s = 30 - k;
        if (s > 0)
            m = (s >= 64) ? 64'd0 : (m >> s);
        else
        begin
            sh = int'(-s);
            if (sh >= 32 || m > (top >> sh))
                m = top + 1;
            else
                m = m << sh;
        end
        if (m > top)
        begin
            flag = 1'b1;
            m = top;
        end
        return (thr_in < 0) ? int'(-longint'(m)) : int'(m);
    endfunction

    // Advance the shadow state by one sample and return the expected word
    function automatic rate_word_t advance_sample(logic [31:0] cov);
        rate_word_t w;
        logic flag;
        longint growth, den, num, base, diff, x;
        int nt;
        flag = 1'b0;
        growth = 0;
        if (n_samples != 32'hFFFF_FFFF)
            n_samples = n_samples + 1;
        if (n_samples >= 2)
        begin
            den = (prev_cov != 0) ? longint'({32'd0, prev_cov}) : 64'sd1;
            num = (longint'({32'd0, cov}) - longint'({32'd0, prev_cov})) * 65536;
            growth = sat_clip(num / den, I32_MIN, I32_MAX, flag);
            rate_sum = sat_clip(rate_sum + growth, SUM_MIN, SUM_MAX, flag);
        end
        prev_cov = cov;
        w.warm = (n_samples >= {16'd0, win_size});
        if (w.warm)
        begin
            base = 0;
            if (n_samples > 1)
                base = sat_clip(rate_sum / longint'({32'd0, n_samples - 32'd1}),
                                I32_MIN, I32_MAX, flag);
            diff = sat_clip(growth - base, I32_MIN, I32_MAX, flag);
            x = (longint'(gain) * diff) >>> 12;
            nt = exp_scale(cur_thr, x, flag);
            cur_thr = (nt > min_thr) ? nt : min_thr;
            w.thr = cur_thr;
        end
        else
            w.thr = min_rate;
        w.growth = growth[31:0];
        w.sat = flag;
        return w;
    endfunction

    // Track configuration, predict on accepted samples, compare accepted words
    always @(posedge clk or negedge rst_n)
    begin
        rate_word_t e;
        if (!rst_n)
        begin
            win_size  = RST_WINDOW_SIZE;
            min_rate  = RST_MIN_GROWTH_RATE;
            gain      = int'($signed(RST_ADJUST_GAIN));
            min_thr   = RST_MIN_THRESHOLD;
            prev_cov  = '0;
            n_samples = '0;
            rate_sum  = 0;
            cur_thr   = RST_MIN_GROWTH_RATE;
            errors    = 0;
            pending   = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:     win_size = cfg_data[15:0];
                    REG_MIN_GROWTH_RATE:
                    begin
                        min_rate = cfg_data;
                        if (n_samples == 0)
                            cur_thr = min_rate;
                    end
                    REG_ADJUST_GAIN:     gain = int'($signed(cfg_data[15:0]));
                    REG_MIN_THRESHOLD:   min_thr = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.insert(expected_words.size(), advance_sample(coverage));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word growth=%h thr=%h warm=%b sat=%b",
                             $time, growth_rate, threshold, warmed_up, saturated);
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.growth !== growth_rate)
                    begin
                        errors++;
                        $display("%0t: growth_rate expected %h actual %h",
                                 $time, e.growth, growth_rate);
                    end
                    if (e.thr !== threshold)
                    begin
                        errors++;
                        $display("%0t: threshold expected %h actual %h",
                                 $time, e.thr, threshold);
                    end
                    if (e.warm !== warmed_up)
                    begin
                        errors++;
                        $display("%0t: warmed_up expected %b actual %b",
                                 $time, e.warm, warmed_up);
                    end
                    if (e.sat !== saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b",
                                 $time, e.sat, saturated);
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

### tb/tb_growth_rate_adaptive_threshold_unit.sv
// Testbench top of the growth rate adaptive threshold unit: stimulus and verdict.
module tb_growth_rate_adaptive_threshold_unit;
    import gratu_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int DRAIN_CYCLES = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] coverage = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] growth_rate;
    logic [31:0] threshold;
    logic        warmed_up;
    logic        saturated;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;

    int          words_sent = 0;
    int          send_pct = 7;
    int          stall_pct = 64;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          cycles = 0;
    logic [31:0] last_cov = '0;

    growth_rate_adaptive_threshold_unit dut (.*);

    growth_rate_adaptive_threshold_checker checker_i (.*);

    always #1 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_growth_rate_adaptive_threshold_unit NOT OK");
            $finish;
        end
    end

    // Hold off the receiver once for a long stretch
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && words_sent == 200)
        begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
    end

    // Drive receiver stall
    always @(posedge clk)
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);

    // Move the idling pattern through its three modes
    always @(posedge clk)
    begin
        if (words_sent < 500)
        begin
            send_pct <= 7;
            stall_pct <= 64;
        end
        else if (words_sent < 1000)
        begin
            send_pct <= 64;
            stall_pct <= 7;
        end
        else
        begin
            send_pct <= 0;
            stall_pct <= 0;
        end
    end

    task automatic send_word(logic [31:0] cov);
        logic ok;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coverage <= cov;
        last_cov = cov;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        logic ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for all words, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic [15:0] win, logic [31:0] rate, logic [15:0] g,
                               logic [31:0] floor_thr);
        write_reg(REG_WINDOW_SIZE, {16'($urandom()), win});
        write_reg(REG_MIN_GROWTH_RATE, rate);
        write_reg(REG_ADJUST_GAIN, {16'($urandom()), g});
        write_reg(REG_MIN_THRESHOLD, floor_thr);
    endtask

    function automatic logic [31:0] next_cov();
        int sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            4: return $urandom_range(0, 16);
            default: return last_cov + $urandom_range(0, 4000) - 32'd800;
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[20];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: first sample, zero previous, extremes, then warmed-up samples
        directed = '{32'd0, 32'd0, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd1,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1000,
                     32'd1100, 32'd1200, 32'd1250, 32'd5000, 32'd10, 32'd11,
                     32'd12, 32'hFFFF_FFFF, 32'd1, 32'd2};
        foreach (directed[i])
            send_word(directed[i]);
        drain();

        // Index beyond three is dropped
        write_reg(8'd4, $urandom());
        write_reg(8'hFF, $urandom());

        // Extreme settings: windows from always warm to never warm, extreme gains and thresholds
        load_config(16'd0, 32'h8000_0000, 16'h7FFF, 32'h8000_0000);
        repeat (60) send_word(next_cov());
        drain();
        load_config(16'd1, 32'h7FFF_FFFF, 16'h8000, 32'h7FFF_FFFF);
        repeat (60) send_word(next_cov());
        drain();
        load_config(16'd65535, 32'd0, 16'd0, 32'd0);
        repeat (120) send_word(next_cov());
        drain();
        load_config(16'd2, -32'sd655, 16'h0400, -32'sd100000);
        repeat (80) send_word(next_cov());
        drain();

        // Random settings with small windows
        while (words_sent < 1500)
        begin
            load_config(16'($urandom_range(0, 24)), $urandom(), 16'($urandom()),
                        ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4000) : $urandom());
            repeat ($urandom_range(60, 160)) send_word(next_cov());
            drain();
        end

        if (errors == 0)
            $display("tb_growth_rate_adaptive_threshold_unit OK");
        else
            $display("tb_growth_rate_adaptive_threshold_unit NOT OK");
        $finish;
    end

endmodule
